// ===== rtl/apc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apc_pkg
// Shared constants, types and protocol codes of the protocol classifier.
// ----------------------------------------------------------------------------
package apc_pkg;

    localparam int BEAT_BYTES = 8;
    localparam int HEAD_N     = 19;
    localparam int BEAT_W     = 13;
    localparam logic [BEAT_W-1:0] BEAT_MAX = 13'd8191;

    typedef logic [4:0] proto_t;

    localparam proto_t P_UNKNOWN = 5'd0;
    localparam proto_t P_MDNS    = 5'd1;
    localparam proto_t P_LLMNR   = 5'd2;
    localparam proto_t P_DNS     = 5'd3;
    localparam proto_t P_HTTP    = 5'd4;
    localparam proto_t P_STUN    = 5'd5;
    localparam proto_t P_DTLS    = 5'd6;
    localparam proto_t P_RTCP    = 5'd7;
    localparam proto_t P_QUIC    = 5'd8;
    localparam proto_t P_TLS     = 5'd9;
    localparam proto_t P_FTP     = 5'd10;
    localparam proto_t P_SSH     = 5'd11;
    localparam proto_t P_TELNET  = 5'd12;
    localparam proto_t P_SMTP    = 5'd13;
    localparam proto_t P_POP3    = 5'd14;
    localparam proto_t P_IMAP    = 5'd15;
    localparam proto_t P_BGP     = 5'd16;
    localparam proto_t P_RDP     = 5'd17;
    localparam proto_t P_LDAP    = 5'd18;
    localparam proto_t P_SSDP    = 5'd19;
    localparam proto_t P_SRVLOC  = 5'd20;
    localparam proto_t P_NBNS    = 5'd21;
    localparam proto_t P_NBDGM   = 5'd22;
    localparam proto_t P_SMB     = 5'd23;
    localparam proto_t P_RTMP    = 5'd24;
    localparam proto_t P_LANSYNC = 5'd25;
    localparam proto_t P_NTP     = 5'd26;
    localparam proto_t P_DHCP    = 5'd27;
    localparam proto_t P_DHCP6   = 5'd28;
    localparam proto_t P_TFTP    = 5'd29;
    localparam proto_t P_SNMP    = 5'd30;

    localparam logic [1:0] KIND_TCP = 2'd1;
    localparam logic [1:0] KIND_UDP = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] src;
        logic [15:0] dst;
        logic [15:0] len;
    } hdr_t;

    typedef logic [HEAD_N-1:0][7:0] head_t;

endpackage
`default_nettype wire

// ===== rtl/apc_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apc_lane
// One byte lane: places its beat byte into the capture buffer positions.
// ----------------------------------------------------------------------------
module apc_lane (
    input  wire logic [12:0] beat,
    input  wire logic [3:0]  lane,
    input  wire logic [15:0] len,
    input  wire logic [7:0]  data,
    output logic             head_we,
    output logic [4:0]       head_idx,
    output logic             cookie_we,
    output logic [1:0]       cookie_idx,
    output logic [7:0]       byte_out
);
    logic [16:0] off;

    always_comb
    begin
        off        = {4'd0, beat} * 17'(apc_pkg::BEAT_BYTES) + {13'd0, lane};
        byte_out   = data;
        head_we    = (off < {1'b0, len}) && (off < 17'd19);
        head_idx   = off[4:0];
        cookie_we  = (off < {1'b0, len}) && (off >= 17'd236) && (off <= 17'd239);
        cookie_idx = off[1:0];
    end
endmodule
`default_nettype wire

// ===== rtl/apc_rules.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// apc_rules
// Ordered rule chain that maps header and captured bytes to a protocol code.
// ----------------------------------------------------------------------------
module apc_rules (
    input  wire apc_pkg::hdr_t   hdr,
    input  wire apc_pkg::head_t  b,
    input  wire logic [31:0]     cookie,
    output apc_pkg::proto_t      proto
);
    function automatic logic st(input apc_pkg::head_t h, input logic [15:0] n,
                                input logic [63:0] s, input int l);
        logic ok;
        ok = (n >= 16'(l));
        for (int i = 0; i < 8; i++)
            if (i < l && h[i] != s[8*(l-1-i) +: 8])
                ok = 1'b0;
        return ok;
    endfunction

    logic tcp, udp;
    logic [15:0] l;
    logic [7:0] b0;
    logic http_b, bgp_m;
    logic [15:0] v12;
    logic [31:0] v14;

    function automatic logic op(input apc_pkg::hdr_t h, input logic [15:0] p);
        return h.src == p || h.dst == p;
    endfunction

    function automatic logic dg(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    always_comb
    begin
        tcp = hdr.kind == apc_pkg::KIND_TCP;
        udp = hdr.kind == apc_pkg::KIND_UDP;
        l   = hdr.len;
        b0  = b[0];
        v12 = {b[1], b[2]};
        v14 = {b[1], b[2], b[3], b[4]};
        bgp_m = 1'b1;
        for (int i = 0; i < 16; i++)
            if (b[i] != 8'hFF)
                bgp_m = 1'b0;
        http_b = st(b, l, 64'("GET "), 4) || st(b, l, 64'("POST "), 5)
            || st(b, l, 64'("PUT "), 4) || st(b, l, 64'("DELETE "), 7)
            || st(b, l, 64'("HEAD "), 5) || st(b, l, 64'("HTTP/"), 5);

        if (udp && op(hdr, 16'd5353) && l >= 12) proto = apc_pkg::P_MDNS;
        else if (udp && op(hdr, 16'd5355) && l >= 12) proto = apc_pkg::P_LLMNR;
        else if (op(hdr, 16'd53) && l >= 12) proto = apc_pkg::P_DNS;
        else if ((op(hdr, 16'd80) || op(hdr, 16'd8080)) && l >= 4 && http_b)
            proto = apc_pkg::P_HTTP;
        else if (udp && l > 0 && (b0 & 8'hC0) == 0 && l >= 20 && b[4] == 8'h21
                 && b[5] == 8'h12 && b[6] == 8'hA4 && b[7] == 8'h42)
            proto = apc_pkg::P_STUN;
        else if (udp && b0 >= 20 && b0 <= 63 && l >= 13
                 && (v12 == 16'hFEFD || v12 == 16'hFEFF || v12 == 16'hFEFC))
            proto = apc_pkg::P_DTLS;
        else if (udp && b0 >= 128 && b0 <= 191 && l >= 8 && b[1] >= 200 && b[1] <= 211)
            proto = apc_pkg::P_RTCP;
        else if (udp && op(hdr, 16'd443) && l >= 1 && b0[7]) proto = apc_pkg::P_QUIC;
        else if (tcp && op(hdr, 16'd443) && l >= 5 && b0 >= 20 && b0 <= 23)
            proto = apc_pkg::P_TLS;
        else if (tcp && op(hdr, 16'd21) && l >= 4 && ((b0 >= 8'h31 && b0 <= 8'h35
                 && dg(b[1]) && dg(b[2]) && (b[3] == 8'h20 || b[3] == 8'h2D))
                 || st(b, l, 64'("USER "), 5) || st(b, l, 64'("PASS "), 5)
                 || st(b, l, 64'("QUIT"), 4) || st(b, l, 64'("SYST"), 4)
                 || st(b, l, 64'("FEAT"), 4) || st(b, l, 64'("CWD "), 4)
                 || st(b, l, 64'("PWD"), 3) || st(b, l, 64'("TYPE "), 5)
                 || st(b, l, 64'("PASV"), 4) || st(b, l, 64'("PORT "), 5)
                 || st(b, l, 64'("LIST"), 4) || st(b, l, 64'("RETR "), 5)
                 || st(b, l, 64'("STOR "), 5) || st(b, l, 64'("DELE "), 5)
                 || st(b, l, 64'("SIZE "), 5) || st(b, l, 64'("NOOP"), 4)
                 || st(b, l, 64'("noop"), 4) || st(b, l, 64'("MKD "), 4)
                 || st(b, l, 64'("RMD "), 4) || st(b, l, 64'("EPSV"), 4)
                 || st(b, l, 64'("EPRT"), 4)))
            proto = apc_pkg::P_FTP;
        else if (tcp && op(hdr, 16'd22) && st(b, l, 64'("SSH-"), 4)) proto = apc_pkg::P_SSH;
        else if (tcp && op(hdr, 16'd23) && l >= 1) proto = apc_pkg::P_TELNET;
        else if (tcp && (op(hdr, 16'd25) || op(hdr, 16'd587)) && l >= 4
                 && (st(b, l, 64'("220 "), 4) || st(b, l, 64'("EHLO "), 5)
                 || st(b, l, 64'("HELO "), 5) || st(b, l, 64'("MAIL "), 5)
                 || st(b, l, 64'("250 "), 4)))
            proto = apc_pkg::P_SMTP;
        else if (tcp && op(hdr, 16'd110) && l >= 3 && (st(b, l, 64'("+OK"), 3)
                 || st(b, l, 64'("-ERR"), 4) || st(b, l, 64'("USER"), 4)
                 || st(b, l, 64'("PASS"), 4)))
            proto = apc_pkg::P_POP3;
        else if (tcp && op(hdr, 16'd143) && l >= 4 && (st(b, l, 64'("* OK"), 4)
                 || st(b, l, 64'("* BYE"), 5) || st(b, l, 64'("* NO"), 4)))
            proto = apc_pkg::P_IMAP;
        else if (tcp && op(hdr, 16'd179) && l >= 19 && bgp_m) proto = apc_pkg::P_BGP;
        else if (tcp && op(hdr, 16'd3389) && l >= 7 && b0 == 8'h03 && b[1] == 8'h00)
            proto = apc_pkg::P_RDP;
        else if (tcp && op(hdr, 16'd389) && l >= 2 && b0 == 8'h30) proto = apc_pkg::P_LDAP;
        else if (udp && op(hdr, 16'd1900) && l >= 4 && (st(b, l, 64'("M-SEARCH"), 8)
                 || st(b, l, 64'("NOTIFY"), 6) || st(b, l, 64'("HTTP/"), 5)))
            proto = apc_pkg::P_SSDP;
        else if (op(hdr, 16'd427) && l >= 5 && (b0 == 1 || b0 == 2))
            proto = apc_pkg::P_SRVLOC;
        else if (udp && op(hdr, 16'd137) && l >= 12) proto = apc_pkg::P_NBNS;
        else if (udp && op(hdr, 16'd138) && l >= 10) proto = apc_pkg::P_NBDGM;
        else if (tcp && ((op(hdr, 16'd445) && l >= 4 && (b0 == 8'hFF || b0 == 8'hFE)
                 && b[1] == 8'h53 && b[2] == 8'h4D && b[3] == 8'h42)
                 || (op(hdr, 16'd139) && l >= 8 && (b[4] == 8'hFF || b[4] == 8'hFE)
                 && b[5] == 8'h53 && b[6] == 8'h4D && b[7] == 8'h42)))
            proto = apc_pkg::P_SMB;
        else if (tcp && op(hdr, 16'd1935) && l >= 1) proto = apc_pkg::P_RTMP;
        else if (udp && op(hdr, 16'd17500) && l >= 2 && b0 == 8'h7B)
            proto = apc_pkg::P_LANSYNC;
        else if (udp && op(hdr, 16'd123) && l >= 48 && (b0[5:3] == 3 || b0[5:3] == 4)
                 && b0[2:0] >= 1 && b0[2:0] <= 5)
            proto = apc_pkg::P_NTP;
        else if (udp && (op(hdr, 16'd67) || op(hdr, 16'd68)) && l >= 240
                 && cookie == 32'h63825363)
            proto = apc_pkg::P_DHCP;
        else if (udp && (op(hdr, 16'd546) || op(hdr, 16'd547)) && l >= 4
                 && b0 >= 1 && b0 <= 13)
            proto = apc_pkg::P_DHCP6;
        else if (udp && op(hdr, 16'd69) && l >= 4 && {b0, b[1]} >= 1 && {b0, b[1]} <= 5)
            proto = apc_pkg::P_TFTP;
        else if (udp && (op(hdr, 16'd161) || op(hdr, 16'd162)) && l >= 2 && b0 == 8'h30)
            proto = apc_pkg::P_SNMP;
        else if (l >= 5 && b0 >= 20 && b0 <= 23 && v12 >= 16'h0300 && v12 <= 16'h0303)
            proto = apc_pkg::P_TLS;
        else if (l >= 4 && (http_b || st(b, l, 64'("OPTIONS "), 8)
                 || st(b, l, 64'("PATCH "), 6)))
            proto = apc_pkg::P_HTTP;
        else if (udp && l >= 5 && b0[7] && (v14 == 32'd1 || v14 == 32'h6b3343cf
                 || v14 == 32'hff000000))
            proto = apc_pkg::P_QUIC;
        else if (st(b, l, 64'("SSH-"), 4)) proto = apc_pkg::P_SSH;
        else if (l >= 19 && bgp_m && b[18] >= 1 && b[18] <= 5) proto = apc_pkg::P_BGP;
        else proto = apc_pkg::P_UNKNOWN;
    end
endmodule
`default_nettype wire

// ===== rtl/app_protocol_classifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// app_protocol_classifier
// Captures packet header and payload bytes over beats in parallel byte
// lanes and classifies the application protocol on the last beat.
// The code is registered and appears in the cycle after the last beat is accepted.
// Throughput: one beat per cycle; ready drops only while a result is held.
// Reset: rst_n clears the beat counter, header and output valid.
// ----------------------------------------------------------------------------
module app_protocol_classifier (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  l4_kind,
    input  wire logic [15:0] src_port,
    input  wire logic [15:0] dst_port,
    input  wire logic [15:0] payload_len,
    input  wire logic [63:0] data_word,
    input  wire logic        last_beat,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       app_protocol
);
    localparam int NB = apc_pkg::BEAT_BYTES;

    apc_pkg::hdr_t  hdr_reg, hdr_cur;
    apc_pkg::head_t head_reg, head_next;
    logic [31:0]    cookie_reg, cookie_next;
    logic [apc_pkg::BEAT_W-1:0] beat_reg;
    logic           out_valid_reg;
    apc_pkg::proto_t proto_reg, proto_c;
    logic           take, first;

    logic [NB-1:0]       hwe, cwe;
    logic [NB-1:0][4:0]  hidx;
    logic [NB-1:0][1:0]  cidx;
    logic [NB-1:0][7:0]  lbyte;

    assign in_ready     = !out_valid_reg || out_ready;
    assign take         = in_valid && in_ready;
    assign first        = beat_reg == '0;
    assign out_valid    = out_valid_reg;
    assign app_protocol = proto_reg;

    always_comb
    begin
        if (first)
        begin
            hdr_cur.kind = l4_kind;
            hdr_cur.len  = payload_len;
            if (l4_kind == apc_pkg::KIND_TCP || l4_kind == apc_pkg::KIND_UDP)
            begin
                hdr_cur.src = src_port;
                hdr_cur.dst = dst_port;
            end
            else
            begin
                hdr_cur.src = '0;
                hdr_cur.dst = '0;
            end
        end
        else
        begin
            hdr_cur = hdr_reg;
        end
    end

    for (genvar k = 0; k < NB; k++)
    begin : g_lane
        apc_lane u_lane (
            .beat       (beat_reg),
            .lane       (4'(k)),
            .len        (hdr_cur.len),
            .data       ((k < 8) ? data_word[(8*k)%64 +: 8] : 8'd0),
            .head_we    (hwe[k]),
            .head_idx   (hidx[k]),
            .cookie_we  (cwe[k]),
            .cookie_idx (cidx[k]),
            .byte_out   (lbyte[k])
        );
    end

    always_comb
    begin
        head_next   = first ? '0 : head_reg;
        cookie_next = first ? '0 : cookie_reg;
        for (int k = 0; k < NB; k++)
        begin
            if (hwe[k])
                head_next[hidx[k]] = lbyte[k];
            if (cwe[k])
                cookie_next[8*(3-int'(cidx[k])) +: 8] = lbyte[k];
        end
    end

    apc_rules u_rules (
        .hdr    (hdr_cur),
        .b      (head_next),
        .cookie (cookie_next),
        .proto  (proto_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg       <= '0;
            beat_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (take)
            begin
                hdr_reg <= hdr_cur;
                if (last_beat)
                begin
                    beat_reg      <= '0;
                    out_valid_reg <= 1'b1;
                end
                else if (beat_reg != apc_pkg::BEAT_MAX)
                begin
                    beat_reg <= beat_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            head_reg   <= head_next;
            cookie_reg <= cookie_next;
            if (last_beat)
                proto_reg <= proto_c;
        end
    end
endmodule
`default_nettype wire
